[hdl/cpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cpq_pkg;

  localparam int DEVICES             = 4;
  localparam int QUEUE_DEPTH         = 32;
  localparam int BATCH_MAX           = 30;
  localparam int CHANNELS_PER_DEVICE = 4;

  localparam int DEV_W     = $clog2(DEVICES);
  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CHAN_W    = $clog2(CHANNELS_PER_DEVICE);
  localparam int BATCH_W   = $clog2(BATCH_MAX + 1);
  localparam int ADDR_W    = DEV_W + SLOT_W;
  localparam int MEM_DEPTH = DEVICES * QUEUE_DEPTH;

  localparam int DCNT_W    = 3;
  localparam int PADDR_W   = 3;

  localparam logic KIND_SET   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [7:0]        ptype;
    logic [31:0]       value;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

[hdl/cpq_qmem.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpq_qmem (
  input  logic              clk,
  input  cpq_pkg::mem_req_t req,
  output cpq_pkg::entry_t   rd_data
);
  import cpq_pkg::*;

  // All device queues share one array; the device number forms the upper address bits.
  entry_t mem [0:MEM_DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/cpq_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module cpq_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           kind,
  input  logic [3:0]                     channel,
  input  logic [7:0]                     param_type,
  input  logic signed [31:0]             param_value,
  input  logic [1:0]                     device,
  input  logic                           dsp_busy,
  input  logic [cpq_pkg::DCNT_W-1:0]     device_count,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           accepted,
  output logic                           merged,
  output logic                           entry_valid,
  output logic [1:0]                     out_channel,
  output logic [7:0]                     out_type,
  output logic signed [31:0]             out_value,
  output logic                           last,
  output cpq_pkg::mem_req_t              mem_req,
  input  cpq_pkg::entry_t                mem_rd_data
);
  import cpq_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SEARCH  = 3'd1;
  localparam logic [2:0] ST_RESULT  = 3'd2;
  localparam logic [2:0] ST_DRN_CHK = 3'd3;
  localparam logic [2:0] ST_DRN_RD  = 3'd4;
  localparam logic [2:0] ST_DRN_OUT = 3'd5;

  logic [2:0]         state;
  logic [SLOT_W-1:0]  head  [DEVICES];
  logic [CNT_W-1:0]   count [DEVICES];
  logic [DEV_W-1:0]   cur_dev;
  logic [CHAN_W-1:0]  cur_chan;
  logic [7:0]         cur_type;
  logic [31:0]        cur_value;
  logic [CNT_W-1:0]   rd_idx;
  logic               cmp_vld;
  logic [SLOT_W-1:0]  cmp_slot;
  logic [BATCH_W-1:0] left;
  logic               pend_acc;
  logic               pend_mrg;

  logic [SLOT_W-1:0]  cur_head;
  logic [CNT_W-1:0]   cur_count;
  logic               key_hit;
  logic               more;
  logic               full;
  logic               out_free;
  logic               load_result;
  logic               accept;
  logic [DEV_W-1:0]   in_dev;
  logic               set_ok;

  assign cur_head    = head[cur_dev];
  assign cur_count   = count[cur_dev];
  assign item_stall  = (state != ST_IDLE);
  assign accept      = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;
  assign load_result = out_free && ((state == ST_RESULT) || (state == ST_DRN_OUT));
  assign in_dev      = channel[3:CHAN_W];
  assign set_ok      = {1'b0, in_dev} < device_count;
  assign more        = rd_idx < cur_count;
  assign full        = cur_count == CNT_W'(QUEUE_DEPTH);

  // Shared key comparator: checks the entry read in the previous cycle.
  assign key_hit = cmp_vld && (mem_rd_data.chan == cur_chan) &&
                   (mem_rd_data.ptype == cur_type);

  always_comb begin
    mem_req.rd_en   = ((state == ST_SEARCH) && !key_hit && more) || (state == ST_DRN_RD);
    mem_req.rd_addr = {cur_dev, (state == ST_DRN_RD) ? cur_head
                                                     : cur_head + rd_idx[SLOT_W-1:0]};
    mem_req.wr_en   = (state == ST_SEARCH) && (key_hit || (!cmp_vld && !more && !full));
    mem_req.wr_addr = {cur_dev, key_hit ? cmp_slot : cur_head + cur_count[SLOT_W-1:0]};
    mem_req.wr_data = '{chan: cur_chan, ptype: cur_type, value: cur_value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cmp_vld      <= 1'b0;
      result_valid <= 1'b0;
      for (int d = 0; d < DEVICES; d++) begin
        head[d]  <= '0;
        count[d] <= '0;
      end
    end else begin
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pend_acc <= 1'b0;
            pend_mrg <= 1'b0;
            cmp_vld  <= 1'b0;
            rd_idx   <= '0;
            if (kind == KIND_SET) begin
              cur_dev   <= in_dev;
              cur_chan  <= channel[CHAN_W-1:0];
              cur_type  <= param_type;
              cur_value <= param_value;
              state     <= set_ok ? ST_SEARCH : ST_RESULT;
            end else begin
              cur_dev <= device;
              state   <= dsp_busy ? ST_RESULT : ST_DRN_CHK;
            end
          end
        end
        ST_SEARCH: begin
          // Reads are issued back to back; each compare sees the previous read.
          if (key_hit) begin
            pend_acc <= 1'b1;
            pend_mrg <= 1'b1;
            state    <= ST_RESULT;
          end else if (more) begin
            rd_idx   <= rd_idx + 1'b1;
            cmp_vld  <= 1'b1;
            cmp_slot <= cur_head + rd_idx[SLOT_W-1:0];
          end else if (cmp_vld) begin
            cmp_vld <= 1'b0;
          end else begin
            if (!full) begin
              count[cur_dev] <= cur_count + 1'b1;
              pend_acc       <= 1'b1;
            end
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            accepted     <= pend_acc;
            merged       <= pend_mrg;
            entry_valid  <= 1'b0;
            out_channel  <= '0;
            out_type     <= '0;
            out_value    <= '0;
            last         <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_DRN_CHK: begin
          if (cur_count == '0) begin
            state <= ST_RESULT;
          end else begin
            left  <= (cur_count > CNT_W'(BATCH_MAX)) ? BATCH_W'(BATCH_MAX)
                                                     : BATCH_W'(cur_count);
            state <= ST_DRN_RD;
          end
        end
        ST_DRN_RD: begin
          state <= ST_DRN_OUT;
        end
        ST_DRN_OUT: begin
          if (out_free) begin
            accepted       <= 1'b0;
            merged         <= 1'b0;
            entry_valid    <= 1'b1;
            out_channel    <= 2'(mem_rd_data.chan);
            out_type       <= mem_rd_data.ptype;
            out_value      <= $signed(mem_rd_data.value);
            last           <= (left == BATCH_W'(1));
            head[cur_dev]  <= cur_head + 1'b1;
            count[cur_dev] <= cur_count - 1'b1;
            left           <= left - 1'b1;
            state          <= (left == BATCH_W'(1)) ? ST_IDLE : ST_DRN_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted item did not start a sequence");

  a_write_in_search: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == ST_SEARCH))
    else $error("queue write outside the key search");

  a_cmp_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && cmp_vld) |-> $past(mem_req.rd_en))
    else $error("compare without a preceding read");

  a_drain_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRN_RD) |-> (left != '0 && CNT_W'(left) <= cur_count))
    else $error("drain runs beyond the queued entries");

  a_drain_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRN_OUT && out_free) |=> (result_valid && entry_valid))
    else $error("drained entry not presented");
`endif

endmodule

`default_nettype wire

[hdl/coalescing_param_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// Coalescing queue of pending DSP parameter writes, one queue per device.
// Items arrive on the item channel (item_valid / item_stall) and results leave
// on the result channel (result_valid / result_stall); a transfer happens when
// valid is high and stall is low. A set item gives exactly one result with last
// high. A drain item gives between 1 and 30 results, the final one with last.
// A set item's key search reads the stored entries of its device queue one per
// cycle through the single memory read port; a set item for a refused device
// does no search. A drain item reads each entry from memory before it is
// loaded into the result register; a busy drain and a drain of an empty queue
// read no entry.
// The block takes no new item while one is in progress, but it accepts the
// next item while the last result still waits in the output register.
// When the receiver stalls, the result register holds and the sequencer waits.
// The user must write device_count over the APB port only while the block is
// idle; the block itself does not enforce this. Reset empties all queues and
// sets device_count to 1; the memory is not cleared and needs no clearing pass.
module coalescing_param_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          kind,
  input  logic [3:0]                    channel,
  input  logic [7:0]                    param_type,
  input  logic signed [31:0]            param_value,
  input  logic [1:0]                    device,
  input  logic                          dsp_busy,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          accepted,
  output logic                          merged,
  output logic                          entry_valid,
  output logic [1:0]                    out_channel,
  output logic [7:0]                    out_type,
  output logic signed [31:0]            out_value,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpq_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cpq_pkg::*;

  localparam logic REG_DEVICE_COUNT = 1'b0;

  logic [DCNT_W-1:0] device_count;
  logic              reg_index;
  mem_req_t          mem_req;
  entry_t            mem_rd_data;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign prdata    = (reg_index == REG_DEVICE_COUNT) ? 32'(device_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= DCNT_W'(1);
    end else if (psel && penable && pwrite && pready && reg_index == REG_DEVICE_COUNT) begin
      device_count <= pwdata[DCNT_W-1:0];
    end
  end

  cpq_qmem u_qmem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  cpq_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .channel      (channel),
    .param_type   (param_type),
    .param_value  (param_value),
    .device       (device),
    .dsp_busy     (dsp_busy),
    .device_count (device_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .merged       (merged),
    .entry_valid  (entry_valid),
    .out_channel  (out_channel),
    .out_type     (out_type),
    .out_value    (out_value),
    .last         (last),
    .mem_req      (mem_req),
    .mem_rd_data  (mem_rd_data)
  );

endmodule

`default_nettype wire
